/* rtl/ntx_pkg.sv */
// Shared types and constants for the four-slot transmit ring block.
// No dependencies; used by ntx_ctrl, ntx_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ntx_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam int LEN_IN_W  = 12;
  localparam int LEN_W     = 11;
  localparam int ISR_W     = 4;
  localparam int POS_W     = 16;
  localparam int OUTC_W    = 4;

  // input kind (travels on tuser)
  localparam logic CMD_TX_REQ = 1'b0;
  localparam logic CMD_IRQ    = 1'b1;

  // interrupt cause bits
  localparam logic [ISR_W-1:0] ISR_RX_OK  = 4'h1;
  localparam logic [ISR_W-1:0] ISR_RX_ERR = 4'h2;
  localparam logic [ISR_W-1:0] ISR_TX_OK  = 4'h4;
  localparam logic [ISR_W-1:0] ISR_NONE   = 4'h0;

  // result codes
  localparam logic [OUTC_W-1:0] OUT_QUEUED      = 4'd0;
  localparam logic [OUTC_W-1:0] OUT_TOO_LONG    = 4'd1;
  localparam logic [OUTC_W-1:0] OUT_FULL        = 4'd2;
  localparam logic [OUTC_W-1:0] OUT_RX_DELIVER  = 4'd3;
  localparam logic [OUTC_W-1:0] OUT_RX_RUNT     = 4'd4;
  localparam logic [OUTC_W-1:0] OUT_TX_DONE     = 4'd5;
  localparam logic [OUTC_W-1:0] OUT_TX_SPURIOUS = 4'd6;
  localparam logic [OUTC_W-1:0] OUT_RX_ERR      = 4'd7;
  localparam logic [OUTC_W-1:0] OUT_UNHANDLED   = 4'd8;

  // receive header bytes
  localparam logic [POS_W-1:0] RX_HDR_BYTES = 16'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // capture the input beat
    logic commit;  // update state and result register
  } ntx_cmd_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot_taken;
    logic              start_valid;
    logic [SLOT_W-1:0] start_slot;
    logic [LEN_W-1:0]  start_length;
    logic [ISR_W-1:0]  ack_bits;
    logic [POS_W-1:0]  rx_offset;
    logic [POS_W-1:0]  rx_length;
  } ntx_result_t;

endpackage

`default_nettype wire

/* rtl/ntx_ctrl.sv */
// Sequencing controller: accept one beat, execute it, hand result to output reg.
// Depends on ntx_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module ntx_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ntx_pkg::ntx_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ntx_dp.sv */
// Datapath: slot ring state, free-slot search, rx offset math, result register.
// Depends on ntx_pkg for widths, codes and structs.
`timescale 1ns / 1ps
`default_nettype none

module ntx_dp #(
  parameter int SLOT_BYTES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ntx_pkg::ntx_cmd_t             cmd,
  input  wire logic                          in_command,
  input  wire logic [ntx_pkg::LEN_IN_W-1:0]  in_frame_length,
  input  wire logic [ntx_pkg::ISR_W-1:0]     in_interrupt_status,
  input  wire logic [ntx_pkg::POS_W-1:0]     in_rx_write_position,
  output ntx_pkg::ntx_result_t               result
);

  localparam logic [ntx_pkg::LEN_IN_W-1:0] SLOT_LIMIT = ntx_pkg::LEN_IN_W'(SLOT_BYTES);

  // captured input beat
  logic                          command;
  logic [ntx_pkg::LEN_IN_W-1:0]  frame_length;
  logic [ntx_pkg::ISR_W-1:0]     interrupt_status;
  logic [ntx_pkg::POS_W-1:0]     rx_write_position;

  // ring state
  logic [ntx_pkg::NUM_SLOTS-1:0] slot_in_use, slot_in_use_next;
  logic                          tx_in_flight, tx_in_flight_next;
  logic [ntx_pkg::SLOT_W-1:0]    next_to_send, next_to_send_next;
  logic [ntx_pkg::LEN_W-1:0]     slot_length [ntx_pkg::NUM_SLOTS];
  logic [ntx_pkg::POS_W-1:0]     last_rx_position, last_rx_position_next;
  logic                          len_write;
  ntx_pkg::ntx_result_t          result_next;

  // free-slot search
  logic [ntx_pkg::SLOT_W-1:0]    free_slot;
  logic                          free_found;
  logic [ntx_pkg::SLOT_W-1:0]    probe;
  logic [ntx_pkg::SLOT_W-1:0]    done_slot;
  logic [ntx_pkg::POS_W-1:0]     rx_size;

  always_comb begin
    free_found = 1'b0;
    free_slot  = next_to_send;
    probe      = next_to_send;
    for (int d = 0; d < ntx_pkg::NUM_SLOTS; d++) begin
      probe = next_to_send + ntx_pkg::SLOT_W'(d);
      if (!free_found && !slot_in_use[probe]) begin
        free_found = 1'b1;
        free_slot  = probe;
      end
    end
  end

  assign done_slot = next_to_send - ntx_pkg::SLOT_W'(1);
  assign rx_size   = (rx_write_position >= last_rx_position) ?
                     (rx_write_position - last_rx_position) : rx_write_position;

  always_comb begin
    result_next           = '0;
    slot_in_use_next      = slot_in_use;
    tx_in_flight_next     = tx_in_flight;
    next_to_send_next     = next_to_send;
    last_rx_position_next = last_rx_position;
    len_write             = 1'b0;

    if (command == ntx_pkg::CMD_TX_REQ) begin
      if (frame_length > SLOT_LIMIT) begin
        result_next.outcome = ntx_pkg::OUT_TOO_LONG;
      end else if (!free_found) begin
        result_next.outcome = ntx_pkg::OUT_FULL;
      end else begin
        result_next.outcome        = ntx_pkg::OUT_QUEUED;
        result_next.slot_taken     = free_slot;
        slot_in_use_next[free_slot] = 1'b1;
        len_write                  = 1'b1;
        if (free_slot == next_to_send && !tx_in_flight) begin
          result_next.start_valid  = 1'b1;
          result_next.start_slot   = next_to_send;
          result_next.start_length = frame_length[ntx_pkg::LEN_W-1:0];
          next_to_send_next        = next_to_send + ntx_pkg::SLOT_W'(1);
          tx_in_flight_next        = 1'b1;
        end
      end
    end else if ((interrupt_status & ntx_pkg::ISR_RX_OK) != ntx_pkg::ISR_NONE) begin
      result_next.ack_bits = ntx_pkg::ISR_RX_OK;
      if (rx_size >= ntx_pkg::RX_HDR_BYTES) begin
        result_next.outcome   = ntx_pkg::OUT_RX_DELIVER;
        result_next.rx_offset = last_rx_position + ntx_pkg::RX_HDR_BYTES;
        result_next.rx_length = rx_size - ntx_pkg::RX_HDR_BYTES;
      end else begin
        result_next.outcome = ntx_pkg::OUT_RX_RUNT;
      end
      last_rx_position_next = rx_write_position;
    end else if ((interrupt_status & ntx_pkg::ISR_TX_OK) != ntx_pkg::ISR_NONE) begin
      result_next.ack_bits = ntx_pkg::ISR_TX_OK;
      if (!tx_in_flight) begin
        result_next.outcome = ntx_pkg::OUT_TX_SPURIOUS;
      end else begin
        result_next.outcome         = ntx_pkg::OUT_TX_DONE;
        slot_in_use_next[done_slot] = 1'b0;
        tx_in_flight_next           = 1'b0;
        // done_slot never equals next_to_send, so the old bit is current
        if (slot_in_use[next_to_send]) begin
          result_next.start_valid  = 1'b1;
          result_next.start_slot   = next_to_send;
          result_next.start_length = slot_length[next_to_send];
          next_to_send_next        = next_to_send + ntx_pkg::SLOT_W'(1);
          tx_in_flight_next        = 1'b1;
        end
      end
    end else if ((interrupt_status & ntx_pkg::ISR_RX_ERR) != ntx_pkg::ISR_NONE) begin
      result_next.outcome  = ntx_pkg::OUT_RX_ERR;
      result_next.ack_bits = ntx_pkg::ISR_RX_ERR;
    end else begin
      result_next.outcome = ntx_pkg::OUT_UNHANDLED;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command           <= in_command;
      frame_length      <= in_frame_length;
      interrupt_status  <= in_interrupt_status;
      rx_write_position <= in_rx_write_position;
    end
    if (cmd.commit) begin
      result <= result_next;
      if (len_write) begin
        slot_length[free_slot] <= frame_length[ntx_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use      <= '0;
      tx_in_flight     <= 1'b0;
      next_to_send     <= '0;
      last_rx_position <= '0;
    end else if (cmd.commit) begin
      slot_in_use      <= slot_in_use_next;
      tx_in_flight     <= tx_in_flight_next;
      next_to_send     <= next_to_send_next;
      last_rx_position <= last_rx_position_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/nic_tx_slot_ring_and_irq_dispatch.sv */
// Top level of the four-slot transmit ring and interrupt dispatch block.
// Instantiates ntx_ctrl and ntx_dp; depends on ntx_pkg.
//
// Usage:
//   Input stream (s_axis_*): one beat per event. tuser carries the kind
//   (0 = transmit request, 1 = interrupt status). Every beat yields exactly
//   one result beat on the output stream (m_axis_*), in order; tuser there
//   carries the outcome code.
//   Sequence: a beat is captured in ST_IDLE when accepted, executed in
//   ST_EXEC once the result register is free, and its result shows on
//   m_axis_tvalid right after the edge that executes it. The accept/execute
//   sequence of the controller keeps one item in the datapath at a time.
//   The result register decouples the sides: a new beat is taken while a
//   result waits, but it holds in execute until the result is taken.
//   A stalled receiver therefore stalls input after one more beat.
//   Reset (rst, synchronous): all slots free, nothing in flight, next slot
//   and rx position at zero, no result pending. Slot lengths are not
//   cleared; a slot's length is only read after it was written.
`timescale 1ns / 1ps
`default_nettype none

module nic_tx_slot_ring_and_irq_dispatch #(
  parameter int SLOT_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] frame_length, [15:12] interrupt_status, [31:16] rx_write_position
  input  wire logic [31:0] s_axis_tdata,
  // [0] command
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] slot_taken, [2] start_valid, [4:3] start_slot, [15:5] start_length,
  // [19:16] ack_bits, [35:20] rx_offset, [51:36] rx_length, [55:52] zero
  output logic [55:0]      m_axis_tdata,
  // [3:0] outcome
  output logic [3:0]       m_axis_tuser
);

  ntx_pkg::ntx_cmd_t    cmd;
  ntx_pkg::ntx_result_t result;

  ntx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  ntx_dp #(
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .in_command           (s_axis_tuser[0]),
    .in_frame_length      (s_axis_tdata[11:0]),
    .in_interrupt_status  (s_axis_tdata[15:12]),
    .in_rx_write_position (s_axis_tdata[31:16]),
    .result               (result)
  );

  // pack result fields, highest field first (slot_taken in the low bits)
  assign m_axis_tuser = result.outcome;
  assign m_axis_tdata = {4'b0000,
                         result.rx_length,
                         result.rx_offset,
                         result.ack_bits,
                         result.start_length,
                         result.start_slot,
                         result.start_valid,
                         result.slot_taken};

endmodule

`default_nettype wire

/* tb/nic_tx_slot_ring_and_irq_dispatch_test.sv */
// Self-checking bench for nic_tx_slot_ring_and_irq_dispatch: directed and random beats
// are checked against an in-bench model of the slot ring. Depends on ntx_pkg and the RTL.
`timescale 1ns / 1ps

module nic_tx_slot_ring_and_irq_dispatch_test;
  import ntx_pkg::*;

  localparam int SLOT_BYTES     = 1024;
  localparam int RANDOM_BEATS   = 1950;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic                cmd;
    logic [LEN_IN_W-1:0] frame_len;
    logic [ISR_W-1:0]    isr;
    logic [POS_W-1:0]    rx_pos;
  } ring_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  ring_beat_t  ring_cmd_q[$];
  ntx_result_t ring_result_q[$];
  int          beats_total = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          mismatch_cnt = 0;

  // model of the ring state
  logic [NUM_SLOTS-1:0] slots_busy = '0;
  logic                 tx_busy = 1'b0;
  logic [SLOT_W-1:0]    send_ptr = '0;
  logic [LEN_W-1:0]     slot_len_mem [NUM_SLOTS] = '{default: '0};
  logic [POS_W-1:0]     rx_last = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nic_tx_slot_ring_and_irq_dispatch #(.SLOT_BYTES(SLOT_BYTES)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // idle cycles before the next beat; every fourth stretch of 64 beats runs flat out
  function automatic int draw_pause();
    if (((beats_in / 64) % 4) == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void start_next_slot(inout ntx_result_t r);
    r.start_valid  = 1'b1;
    r.start_slot   = send_ptr;
    r.start_length = slot_len_mem[send_ptr];
    send_ptr       = send_ptr + 2'd1;
    tx_busy        = 1'b1;
  endfunction

  function automatic ntx_result_t predict_ring_beat(input ring_beat_t b);
    ntx_result_t       r;
    logic [POS_W-1:0]  rx_size;
    logic [SLOT_W-1:0] probe;
    logic              found;
    r = '0;
    if (b.cmd == CMD_TX_REQ) begin
      if (b.frame_len > SLOT_BYTES) begin
        r.outcome = OUT_TOO_LONG;
      end else begin
        found = 1'b0;
        for (int d = 0; d < NUM_SLOTS; d++) begin
          probe = send_ptr + SLOT_W'(d);
          if (!found && !slots_busy[probe]) begin
            found = 1'b1;
            r.slot_taken = probe;
          end
        end
        if (!found) begin
          r.outcome = OUT_FULL;
        end else begin
          slots_busy[r.slot_taken]   = 1'b1;
          slot_len_mem[r.slot_taken] = b.frame_len[LEN_W-1:0];
          r.outcome = OUT_QUEUED;
          if (r.slot_taken == send_ptr && !tx_busy) start_next_slot(r);
        end
      end
    end else if ((b.isr & ISR_RX_OK) != ISR_NONE) begin
      // wrapped write pointer: the new position is taken as the size
      rx_size    = (b.rx_pos >= rx_last) ? b.rx_pos - rx_last : b.rx_pos;
      r.ack_bits = ISR_RX_OK;
      if (rx_size >= RX_HDR_BYTES) begin
        r.outcome   = OUT_RX_DELIVER;
        r.rx_offset = rx_last + RX_HDR_BYTES;
        r.rx_length = rx_size - RX_HDR_BYTES;
      end else begin
        r.outcome = OUT_RX_RUNT;
      end
      rx_last = b.rx_pos;
    end else if ((b.isr & ISR_TX_OK) != ISR_NONE) begin
      r.ack_bits = ISR_TX_OK;
      if (!tx_busy) begin
        r.outcome = OUT_TX_SPURIOUS;
      end else begin
        slots_busy[send_ptr - 2'd1] = 1'b0;
        tx_busy   = 1'b0;
        r.outcome = OUT_TX_DONE;
        if (slots_busy[send_ptr]) start_next_slot(r);
      end
    end else if ((b.isr & ISR_RX_ERR) != ISR_NONE) begin
      r.outcome  = OUT_RX_ERR;
      r.ack_bits = ISR_RX_ERR;
    end else begin
      r.outcome = OUT_UNHANDLED;
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_cnt < MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic push_beat(input logic cmd, input logic [LEN_IN_W-1:0] len,
                           input logic [ISR_W-1:0] isr, input logic [POS_W-1:0] pos);
    ring_cmd_q.push_back('{cmd: cmd, frame_len: len, isr: isr, rx_pos: pos});
    beats_total++;
  endtask

  // input side: present queued beats, predict each one as it is taken
  always @(posedge clk) begin : drive_in
    ring_beat_t cur_beat;
    int         in_pause;
    logic       fire;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_pause = 0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        ring_result_q.push_back(predict_ring_beat(cur_beat));
        beats_in <= beats_in + 1;
        in_pause = draw_pause();
      end
      if (s_axis_tvalid && !fire) begin
        // hold the beat until taken
      end else if (in_pause != 0) begin
        in_pause--;
        s_axis_tvalid <= 1'b0;
      end else if (ring_cmd_q.size() != 0) begin
        cur_beat = ring_cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_beat.rx_pos, cur_beat.isr, cur_beat.frame_len};
        s_axis_tuser  <= cur_beat.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random back-pressure, compare against the oldest prediction
  always @(posedge clk) begin : watch_out
    ntx_result_t want;
    int          out_pause;
    logic        fire;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_pause = 0;
    end else begin
      fire = m_axis_tvalid && m_axis_tready;
      if (fire) begin
        if (beats_out >= beats_in) begin
          if (mismatch_cnt < MAX_REPORTS)
            $error("result beat with no prediction pending, outcome %0d", m_axis_tuser);
          mismatch_cnt++;
        end else begin
          want = ring_result_q.pop_front();
          beats_out <= beats_out + 1;
          check_field("outcome",      want.outcome,      m_axis_tuser);
          check_field("slot_taken",   want.slot_taken,   m_axis_tdata[1:0]);
          check_field("start_valid",  want.start_valid,  m_axis_tdata[2]);
          check_field("start_slot",   want.start_slot,   m_axis_tdata[4:3]);
          check_field("start_length", want.start_length, m_axis_tdata[15:5]);
          check_field("ack_bits",     want.ack_bits,     m_axis_tdata[19:16]);
          check_field("rx_offset",    want.rx_offset,    m_axis_tdata[35:20]);
          check_field("rx_length",    want.rx_length,    m_axis_tdata[51:36]);
          check_field("tdata pad",    '0,                m_axis_tdata[55:52]);
        end
        out_pause = draw_pause();
      end
      if (out_pause != 0) begin
        out_pause--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [POS_W-1:0]    rx_track;
    logic [POS_W-1:0]    pos_v;
    logic [ISR_W-1:0]    isr_v;
    logic [LEN_IN_W-1:0] len_v;
    int                  pick;

    // idle ring, odd causes
    push_beat(CMD_IRQ, 12'($urandom), ISR_TX_OK, 16'h0000);   // tx ok with nothing in flight
    push_beat(CMD_IRQ, 12'($urandom), ISR_NONE, 16'hFFFF);    // no cause
    push_beat(CMD_IRQ, 12'($urandom), 4'h8, 16'($urandom));   // tx error alone
    // length limits
    push_beat(CMD_TX_REQ, 12'd1025, 4'($urandom), 16'($urandom));
    push_beat(CMD_TX_REQ, 12'hFFF, 4'($urandom), 16'($urandom));
    push_beat(CMD_TX_REQ, 12'd0, 4'($urandom), 16'($urandom));     // slot 0, starts
    push_beat(CMD_TX_REQ, 12'd1024, 4'($urandom), 16'($urandom));  // slot 1
    push_beat(CMD_TX_REQ, 12'd1, 4'($urandom), 16'($urandom));     // slot 2
    push_beat(CMD_TX_REQ, 12'd555, 4'($urandom), 16'($urandom));   // slot 3
    push_beat(CMD_TX_REQ, 12'd100, 4'($urandom), 16'($urandom));   // ring full
    push_beat(CMD_IRQ, 12'($urandom), ISR_TX_OK, 16'($urandom));   // done 0, start 1
    push_beat(CMD_IRQ, 12'($urandom), 4'h6, 16'($urandom));        // tx ok wins over rx error
    push_beat(CMD_TX_REQ, 12'd700, 4'($urandom), 16'($urandom));   // reuses slot 0, no start
    // receive positions: normal, runt, wrap, offset wrap
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'h0100);
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'h0102);
    push_beat(CMD_IRQ, 12'($urandom), 4'hF, 16'h0010);             // rx ok first, wrap
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'hFFFE);
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'h0008);        // offset wraps past 0xFFFF
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'h0002);        // wrap, short
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_OK, 16'h0002);        // zero size
    push_beat(CMD_IRQ, 12'($urandom), ISR_RX_ERR, 16'($urandom));
    push_beat(CMD_IRQ, 12'($urandom), 4'hA, 16'($urandom));        // rx error with tx error
    repeat (3) push_beat(CMD_IRQ, 12'($urandom), ISR_TX_OK, 16'($urandom));
    rx_track = 16'h0002;

    // random traffic, mostly requests and completions that keep the ring cycling
    repeat (RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)      len_v = 12'($urandom_range(0, SLOT_BYTES));
        else if (pick < 95) len_v = 12'($urandom_range(SLOT_BYTES + 1, 4095));
        else                len_v = 12'(SLOT_BYTES + $urandom_range(0, 1));
        push_beat(CMD_TX_REQ, len_v, 4'($urandom), 16'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      isr_v = {1'($urandom), 1'b1, 1'($urandom), 1'b0};
        else if (pick < 75) isr_v = {3'($urandom), 1'b1};
        else if (pick < 90) isr_v = {1'($urandom), 1'b0, 1'b1, 1'b0};
        else                isr_v = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)      pos_v = rx_track + 16'($urandom_range(0, 1600));
        else if (pick < 75) pos_v = rx_track + 16'($urandom_range(0, 3));
        else                pos_v = 16'($urandom);
        if (isr_v[0]) rx_track = pos_v;
        push_beat(CMD_IRQ, 12'($urandom), isr_v, pos_v);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (beats_in != beats_total || beats_out != beats_in);
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* nic_tx_slot_ring_and_irq_dispatch.f */
rtl/ntx_pkg.sv
rtl/ntx_ctrl.sv
rtl/ntx_dp.sv
rtl/nic_tx_slot_ring_and_irq_dispatch.sv
tb/nic_tx_slot_ring_and_irq_dispatch_test.sv
